// ===== rtl/assert_macros.svh =====
// Assertion macros for the verification-only files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define ASSERT_DFLT(label, prop, msg) `ASSERT_RST(label, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/fmi_pkg.sv =====
// Constants and types shared by the modular inverse pipeline.
package fmi_pkg;

  localparam int unsigned Width = 30;
  localparam int unsigned MuWidth = Width + 1;

  localparam logic [Width-1:0] Modulus = 30'd998244353;
  localparam logic [Width-1:0] Exponent = Modulus - 30'd2;

  // Barrett constant floor(2^(2*Width) / Modulus).
  localparam logic [MuWidth-1:0] BarrettMu =
    MuWidth'((64'd1 << (2 * Width)) / 64'(Modulus));

  localparam int unsigned MulLatency = 4;
  localparam int unsigned PipeDepth = 1 + Width * MulLatency;
  localparam int unsigned InFlightMax = PipeDepth + 2;

  typedef logic [Width-1:0] residue_t;

endpackage

// ===== rtl/fmi_mulmod.sv =====
// Four-stage pipelined multiplier modulo the prime, with Barrett reduction.
module fmi_mulmod (
  input  logic              clk_i,
  input  logic              en_i,
  input  fmi_pkg::residue_t a_i,
  input  fmi_pkg::residue_t b_i,
  output fmi_pkg::residue_t y_o
);

  localparam int unsigned W = fmi_pkg::Width;

  logic [2*W-1:0] prod_q;
  logic [2*W+1:0] est_q;
  logic [W+1:0]   plo_q;
  logic [W+1:0]   rem_q;
  logic [W-1:0]   y_q;

  logic [2*W-1:0] prod_d;
  logic [2*W+1:0] est_d;
  logic [W+1:0]   qm;
  logic [W+1:0]   rem_d;
  logic [W+1:0]   mod_x1;
  logic [W+1:0]   mod_x2;
  logic [W-1:0]   y_d;

  always_comb begin
    prod_d = (2*W)'(a_i) * (2*W)'(b_i);
    est_d  = (2*W+2)'(prod_q[2*W-1:W-1]) * (2*W+2)'(fmi_pkg::BarrettMu);
    // Only the low bits matter: the true remainder is below three moduli.
    qm     = (W+2)'(est_q[2*W+1:W+1]) * (W+2)'(fmi_pkg::Modulus);
    rem_d  = plo_q - qm;
    mod_x1 = (W+2)'(fmi_pkg::Modulus);
    mod_x2 = mod_x1 << 1;
    if (rem_q >= mod_x2) begin
      y_d = W'(rem_q - mod_x2);
    end else if (rem_q >= mod_x1) begin
      y_d = W'(rem_q - mod_x1);
    end else begin
      y_d = W'(rem_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      est_q  <= est_d;
      plo_q  <= prod_q[W+1:0];
      rem_q  <= rem_d;
      y_q    <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

// ===== rtl/fmi_cell.sv =====
// One exponent bit of square-and-multiply: optional multiply into the
// accumulator and squaring of the base, both pipelined.
module fmi_cell #(
  parameter bit MulAcc = 1'b1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  fmi_pkg::residue_t acc_i,
  input  fmi_pkg::residue_t sq_i,
  output logic              valid_o,
  output fmi_pkg::residue_t acc_o,
  output fmi_pkg::residue_t sq_o
);

  localparam int unsigned L = fmi_pkg::MulLatency;

  logic [L-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[L-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[L-1];

  if (MulAcc) begin : g_mul
    fmi_mulmod u_acc_mul (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (acc_i),
      .b_i   (sq_i),
      .y_o   (acc_o)
    );
  end else begin : g_dly
    // The accumulator waits alongside the squaring unit.
    fmi_pkg::residue_t [L-1:0] acc_dly_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_dly_q <= {acc_dly_q[L-2:0], acc_i};
      end
    end

    assign acc_o = acc_dly_q[L-1];
  end

  fmi_mulmod u_sq_mul (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (sq_i),
    .b_i   (sq_i),
    .y_o   (sq_o)
  );

endmodule

// ===== rtl/fermat_modular_inverse_core.sv =====
// Top level of the modular inverse pipeline modulo 998244353.
//
// Usage: a request carries one 30-bit residue on value_i over a valid/ready
// channel; each request yields one 30-bit result on inverse_o over a second
// valid/ready channel, in request order. The result is value^(p-2) mod p,
// which is the inverse for nonzero residues and zero for zero. An input at
// or above the modulus is first reduced by one subtraction.
// The datapath is a row of 30 cells, one per exponent bit; each holds a
// four-stage modular multiplier for the square and, where the bit is set,
// a second one for the multiply. A request passes one input stage, the 30
// cells of 4 stages and one output register. Throughput: one request per
// cycle while in_ready_o is high.
// When the receiver stalls, the output register holds its result and a skid
// register catches one more; once the skid register is full, in_ready_o
// drops and the whole row freezes until the output is taken.
// Reset clears all valid flags; no result is pending afterwards.
module fermat_modular_inverse_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [29:0]       value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [29:0]       inverse_o
);

  localparam int unsigned W = fmi_pkg::Width;

  logic en;

  logic              in_vld_q;
  fmi_pkg::residue_t in_val_q;
  fmi_pkg::residue_t in_val_d;

  logic [W:0]                   vld_c;
  fmi_pkg::residue_t [W:0]      acc_c;
  fmi_pkg::residue_t [W-1:0]    sq_c;

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  fmi_pkg::residue_t out_data_q, out_data_d;
  fmi_pkg::residue_t skid_data_q, skid_data_d;
  logic              out_fire;

  assign en = ~skid_valid_q;
  assign in_ready_o = en;

  always_comb begin
    if (value_i >= fmi_pkg::Modulus) begin
      in_val_d = value_i - fmi_pkg::Modulus;
    end else begin
      in_val_d = value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_val_q <= in_val_d;
    end
  end

  assign vld_c[0] = in_vld_q;
  assign acc_c[0] = fmi_pkg::residue_t'(1);
  assign sq_c[0]  = in_val_q;

  for (genvar i = 0; i < W; i++) begin : g_cell
    if (i < W - 1) begin : g_mid
      fmi_cell #(
        .MulAcc (fmi_pkg::Exponent[i])
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (vld_c[i]),
        .acc_i   (acc_c[i]),
        .sq_i    (sq_c[i]),
        .valid_o (vld_c[i+1]),
        .acc_o   (acc_c[i+1]),
        .sq_o    (sq_c[i+1])
      );
    end else begin : g_last
      // The last square is never needed.
      fmi_cell #(
        .MulAcc (fmi_pkg::Exponent[i])
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (vld_c[i]),
        .acc_i   (acc_c[i]),
        .sq_i    (sq_c[i]),
        .valid_o (vld_c[i+1]),
        .acc_o   (acc_c[i+1]),
        .sq_o    ()
      );
    end
  end

  assign out_fire = out_valid_q & out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (vld_c[W]) begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_d = 1'b1;
        out_data_d  = acc_c[W];
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = acc_c[W];
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign inverse_o   = out_data_q;

endmodule

// ===== rtl/fmi_checker.sv =====
// Port-level assertions for the modular inverse core, bound to the top level.
`include "assert_macros.svh"

module fmi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [29:0] value_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [29:0] inverse_o
);

  localparam int unsigned CntW = $clog2(fmi_pkg::InFlightMax + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            in_acc, out_acc;
  logic [29:0]     unused_value;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;
  assign cnt_d   = cnt_q + CntW'(in_acc) - CntW'(out_acc);

  // The request payload itself is not checked here.
  assign unused_value = value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `ASSERT_DFLT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(inverse_o), "stalled result changed")
  `ASSERT_DFLT(a_no_spurious, out_valid_o |-> cnt_q != '0, "result without a pending request")
  `ASSERT_DFLT(a_bound, cnt_q <= CntW'(fmi_pkg::InFlightMax), "too many requests in flight")
  `ASSERT_DFLT(a_ready_back, !in_ready_o && out_valid_o && out_ready_i |=> in_ready_o, "ready did not return after the output drained")
  `ASSERT_DFLT(a_range, out_valid_o |-> inverse_o < fmi_pkg::Modulus, "result not reduced")

endmodule

bind fermat_modular_inverse_core fmi_checker u_fmi_checker (.*);

// ===== tb/sv/fermat_modular_inverse_core_tb.sv =====
// Testbench for the modular inverse pipeline modulo 998244353.
`timescale 1ns / 100ps

module fermat_modular_inverse_core_tb;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned TailCycles = 130;
  localparam longint unsigned ModulusWide = 64'(fmi_pkg::Modulus);
  localparam fmi_pkg::residue_t ValueMax = '1;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  fmi_pkg::residue_t value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  fmi_pkg::residue_t inverse_o;

  fmi_pkg::residue_t pending_inverses[$];
  int unsigned       mismatch_count = 0;
  int unsigned       quiet_cycles = 0;

  fermat_modular_inverse_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .inverse_o   (inverse_o)
  );

  always #5 clk_i = ~clk_i;

  // Square-and-multiply over the fixed exponent, with full reduction of the input.
  function automatic fmi_pkg::residue_t fermat_inverse(fmi_pkg::residue_t value);
    longint unsigned acc;
    longint unsigned sq;
    acc = 1;
    sq = longint'(value) % ModulusWide;
    for (int b = 0; b < fmi_pkg::Width; b++) begin
      if (fmi_pkg::Exponent[b]) begin
        acc = (acc * sq) % ModulusWide;
      end
      sq = (sq * sq) % ModulusWide;
    end
    return fmi_pkg::residue_t'(acc);
  endfunction

  function automatic fmi_pkg::residue_t random_value();
    case ($urandom_range(0, 19))
      0: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return fmi_pkg::residue_t'(1);
          2: return fmi_pkg::Modulus - fmi_pkg::residue_t'(1);
          3: return fmi_pkg::Modulus;
          default: return ValueMax;
        endcase
      end
      1, 2: return fmi_pkg::residue_t'($urandom_range(int'(fmi_pkg::Modulus), int'(ValueMax)));
      default: return fmi_pkg::residue_t'($urandom_range(0, int'(fmi_pkg::Modulus) - 1));
    endcase
  endfunction

  // Holds the request until it is taken, then records the expected inverse.
  task automatic send_value(fmi_pkg::residue_t value);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    pending_inverses = {pending_inverses, fermat_inverse(value)};
  endtask

  task automatic sender_idle(int unsigned cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic wait_for_drain();
    while (pending_inverses.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_values();
    fmi_pkg::residue_t corner[$];
    corner = '{'0, fmi_pkg::residue_t'(1), fmi_pkg::residue_t'(2), fmi_pkg::residue_t'(3),
               fmi_pkg::Modulus - fmi_pkg::residue_t'(2),
               fmi_pkg::Modulus - fmi_pkg::residue_t'(1), fmi_pkg::Modulus,
               fmi_pkg::Modulus + fmi_pkg::residue_t'(1), ValueMax,
               (fmi_pkg::Modulus >> 1) + fmi_pkg::residue_t'(1),
               fmi_pkg::residue_t'(1) << 29, fmi_pkg::residue_t'(1) << 15,
               30'h2AAAAAAA, 30'h15555555, 30'h3FFFFFFE, 30'h1FFFFFFF};
    // Back to back, so the directed part also covers a stretch without gaps.
    foreach (corner[i]) begin
      send_value(corner[i]);
    end
    sender_idle(1);
  endtask

  task automatic test_random_bursts(int unsigned count);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 32);
      for (int unsigned i = 0; i < burst && sent < count; i++) begin
        send_value(random_value());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        sender_idle($urandom_range(1, 12));
      end
    end
    sender_idle(1);
  endtask

  // The pipeline empties completely before the next burst starts.
  task automatic test_drain_pause();
    repeat (20) send_value(random_value());
    sender_idle(1);
    wait_for_drain();
    repeat (20) send_value(random_value());
    sender_idle(1);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_values();
    test_random_bursts(170);
    test_drain_pause();
    test_random_bursts(170);
    wait_for_drain();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // The receiver alternates ready runs and stalls of random length.
  initial begin
    bit          ready_now;
    int unsigned hold_left;
    ready_now = 1'b0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left == 0) begin
        ready_now = !ready_now;
        if (ready_now) begin
          hold_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 40);
        end else begin
          hold_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 5);
        end
      end
      out_ready_i <= ready_now;
      hold_left--;
    end
  end

  always @(posedge clk_i) begin
    fmi_pkg::residue_t expected;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_inverses.size() == 0) begin
        $error("inverse: unexpected result 0x%08h with no request pending", inverse_o);
        mismatch_count++;
      end else begin
        expected = pending_inverses.pop_front();
        if (inverse_o !== expected) begin
          $error("inverse: expected 0x%08h, actual 0x%08h", expected, inverse_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
